// ----- sv/bfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Beacon frequency detector package
// Field widths, register indexes and reset values shared by the detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int CLK_W   = 25;
    localparam int EDGE_W  = 5;
    localparam int HZ_W    = 16;
    localparam int SUM_W   = TIME_W + 3;
    localparam int DIV_W   = TIME_W + EDGE_W;
    localparam int CNT_W   = 6;
    localparam int IDX_W   = 8;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_TIMER_CLOCK = 8'd0;
    localparam logic [IDX_W-1:0] REG_EDGES       = 8'd1;
    localparam logic [IDX_W-1:0] REG_TARGET      = 8'd2;
    localparam logic [IDX_W-1:0] REG_TOLERANCE   = 8'd3;

    // Register reset values.
    localparam logic [CLK_W-1:0]  RST_TIMER_CLOCK = 25'd78125;
    localparam logic [EDGE_W-1:0] RST_EDGES       = 5'd16;
    localparam logic [HZ_W-1:0]   RST_TARGET      = 16'd1427;
    localparam logic [HZ_W-1:0]   RST_TOLERANCE   = 16'd50;

    // Smoothing divisor; the old value is weighted by one less than this.
    localparam logic [3:0] SMOOTH_DIV = 4'd6;

endpackage

`default_nettype wire

// ----- sv/beacon_frequency_detector_unit.sv -----
// ----------------------------------------------------------------------------
// Beacon frequency detector unit
// Measures the period between capture timestamps, smooths it, converts it to
// a frequency with a bit-serial divider and flags a beacon inside a window.
// ----------------------------------------------------------------------------
// Sequence from the accepting edge: straight to the output on the first edge,
// through the frequency divider on the seeding edge, and afterwards through 35
// steps of the divide-by-6 shifter and 25 steps of the frequency divider (one
// quotient bit per cycle each); a zero divisor skips the frequency divider.
// A new capture is taken only once the last result is in the output register;
// a stalled result holds the sequencer. Reset: synchronous active-low, restores
// register defaults and forgets the previous edge and the smoothed period.
`default_nettype none

module beacon_frequency_detector_unit
    import bfd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Capture channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [TIME_W-1:0] i_capture_time,
    // Result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_freq_valid,
    output logic [CLK_W-1:0]       o_frequency_hz,
    output logic                   o_beacon_detected,
    // Configuration channel
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [CLK_W-1:0]  i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL5 = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV6 = 3'd3;
    localparam logic [2:0] ST_PREP = 3'd4;
    localparam logic [2:0] ST_DIVF = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    // Configuration registers.
    logic [CLK_W-1:0]  r_timer_clock;
    logic [EDGE_W-1:0] r_edges;
    logic [HZ_W-1:0]   r_target;
    logic [HZ_W-1:0]   r_tolerance;

    // Measurement state.
    logic [TIME_W-1:0] r_last_time;
    logic              r_have_last;
    logic [TIME_W-1:0] r_smooth;
    logic              r_seeded;

    // Sequencer and datapath registers.
    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_period;
    logic [SUM_W-1:0]  r_sum;
    logic [2:0]        r_rem6;
    logic [TIME_W-1:0] r_quo6;
    logic [DIV_W-1:0]  r_divisor;
    logic [CLK_W-1:0]  r_dvd;
    logic [CLK_W-1:0]  r_remf;
    logic [CLK_W-1:0]  r_freq;
    logic              r_item_valid;

    // Output register.
    logic              r_out_valid;
    logic              r_out_fvalid;
    logic [CLK_W-1:0]  r_out_freq;
    logic              r_out_det;

    logic              in_xfer;
    logic              out_free;
    logic [TIME_W-1:0] period;
    logic [3:0]        part6;
    logic              ge6;
    logic [CLK_W:0]    partf;
    logic              gef;
    logic [CLK_W:0]    difff;
    logic [HZ_W-1:0]   win_lo;
    logic [HZ_W:0]     win_hi;
    logic              detect;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_freq_valid      = r_out_fvalid;
    assign o_frequency_hz    = r_out_freq;
    assign o_beacon_detected = r_out_det;

    // Period since the previous edge, wrapping modulo 2^32.
    assign period = i_capture_time - r_last_time;

    // One step of the divide-by-6: bring in the next sum bit.
    assign part6 = {r_rem6, r_sum[SUM_W-1]};
    assign ge6   = (part6 >= SMOOTH_DIV);

    // One step of the frequency divider: bring in the next clock bit.
    assign partf = {r_remf, r_dvd[CLK_W-1]};
    assign gef   = ({{(DIV_W-CLK_W-1){1'b0}}, partf} >= r_divisor);
    assign difff = partf - r_divisor[CLK_W:0];

    // Detection window, lower bound floored at zero.
    assign win_lo = (r_target > r_tolerance) ? (r_target - r_tolerance) : '0;
    assign win_hi = {1'b0, r_target} + {1'b0, r_tolerance};
    assign detect = r_item_valid
                    && (r_freq >= {{(CLK_W-HZ_W){1'b0}}, win_lo})
                    && (r_freq <= {{(CLK_W-HZ_W-1){1'b0}}, win_hi});

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_clock <= RST_TIMER_CLOCK;
            r_edges       <= RST_EDGES;
            r_target      <= RST_TARGET;
            r_tolerance   <= RST_TOLERANCE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TIMER_CLOCK: r_timer_clock <= i_cfg_data;
                REG_EDGES:       r_edges       <= i_cfg_data[EDGE_W-1:0];
                REG_TARGET:      r_target      <= i_cfg_data[HZ_W-1:0];
                REG_TOLERANCE:   r_tolerance   <= i_cfg_data[HZ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control state of the sequencer and the measurement history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_have_last <= 1'b0;
            r_seeded    <= 1'b0;
            r_last_time <= '0;
            r_smooth    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A transfer empties the output register unless a new result is
            // loaded in the same cycle.
            if (r_out_valid && i_out_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_last_time <= i_capture_time;
                        r_have_last <= 1'b1;
                        if (!r_have_last) begin
                            r_state <= ST_DONE;
                        end else if (!r_seeded) begin
                            r_smooth <= period;
                            r_seeded <= 1'b1;
                            r_state  <= ST_PREP;
                        end else begin
                            r_state <= ST_MUL5;
                        end
                    end
                end
                ST_MUL5: r_state <= ST_SUM;
                ST_SUM:  r_state <= ST_DIV6;
                ST_DIV6: begin
                    if (r_cnt == CNT_W'(SUM_W - 1)) begin
                        r_smooth <= {r_quo6[TIME_W-2:0], ge6};
                        r_state  <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    if (r_smooth == '0 || r_edges == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_DIVF;
                    end
                end
                ST_DIVF: begin
                    if (r_cnt == CNT_W'(CLK_W - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath: shift registers and the serial dividers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_period     <= period;
                r_item_valid <= r_have_last;
                r_freq       <= '0;
            end
            ST_MUL5: begin
                // Five times the smoothed period, without wrapping.
                r_sum <= {1'b0, r_smooth, 2'b00} + {3'b000, r_smooth};
            end
            ST_SUM: begin
                r_sum  <= r_sum + {3'b000, r_period};
                r_rem6 <= '0;
                r_cnt  <= '0;
            end
            ST_DIV6: begin
                r_rem6 <= ge6 ? 3'(part6 - SMOOTH_DIV) : part6[2:0];
                r_quo6 <= {r_quo6[TIME_W-2:0], ge6};
                r_sum  <= {r_sum[SUM_W-2:0], 1'b0};
                r_cnt  <= r_cnt + 1'b1;
            end
            ST_PREP: begin
                r_divisor <= {{EDGE_W{1'b0}}, r_smooth} * {{TIME_W{1'b0}}, r_edges};
                r_dvd     <= r_timer_clock;
                r_remf    <= '0;
                r_freq    <= '0;
                r_cnt     <= '0;
            end
            ST_DIVF: begin
                r_remf <= gef ? difff[CLK_W-1:0] : partf[CLK_W-1:0];
                r_freq <= {r_freq[CLK_W-2:0], gef};
                r_dvd  <= {r_dvd[CLK_W-2:0], 1'b0};
                r_cnt  <= r_cnt + 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_fvalid <= r_item_valid;
                    r_out_freq   <= r_freq;
                    r_out_det    <= detect;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Beacon frequency detector testbench
// Feeds capture timestamps through the valid/ready channels, predicts each
// smoothed frequency and beacon flag, and checks every result in order while
// the register settings and the handshake pacing change from phase to phase.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfd_pkg::*;

    // Indexes outside the register map; writes to them must change nothing.
    localparam logic [IDX_W-1:0] IDX_UNMAPPED_LO = 8'd4;
    localparam logic [IDX_W-1:0] IDX_UNMAPPED_HI = 8'hFF;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 175;
    localparam int SETTLE      = 100;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int MAX_FREQ    = 20_000_000;

    typedef struct packed {
        logic             valid;
        logic [CLK_W-1:0] freq;
        logic             detect;
    } t_freq_result;

    // Tracks the detector state and the frequencies still owed by the block.
    class frequency_board;
        logic [CLK_W-1:0]  timer_clock;
        logic [EDGE_W-1:0] edges;
        logic [HZ_W-1:0]   target;
        logic [HZ_W-1:0]   tolerance;
        logic [TIME_W-1:0] last_time;
        logic [TIME_W-1:0] smoothed;
        bit                have_last;
        bit                seeded;
        t_freq_result      owed_freqs[$];
        int                errors;
        int                results;
        int                hits;

        function new();
            timer_clock = RST_TIMER_CLOCK;
            edges       = RST_EDGES;
            target      = RST_TARGET;
            tolerance   = RST_TOLERANCE;
            last_time   = '0;
            smoothed    = '0;
            have_last   = 1'b0;
            seeded      = 1'b0;
            errors      = 0;
            results     = 0;
            hits        = 0;
        endfunction

        // Register writes keep only the bits of the register's width.
        function void write_reg(logic [IDX_W-1:0] idx, logic [CLK_W-1:0] data);
            case (idx)
                REG_TIMER_CLOCK: timer_clock = data;
                REG_EDGES:       edges       = data[EDGE_W-1:0];
                REG_TARGET:      target      = data[HZ_W-1:0];
                REG_TOLERANCE:   tolerance   = data[HZ_W-1:0];
                default: ;
            endcase
        endfunction

        // Works out the result caused by one capture transfer.
        function void predict_capture(logic [TIME_W-1:0] now);
            t_freq_result      r;
            logic [TIME_W-1:0] period;
            logic [SUM_W-1:0]  sum;
            logic [DIV_W-1:0]  divisor;
            logic [HZ_W:0]     lo;
            logic [HZ_W:0]     hi;
            r = '0;
            if (have_last) begin
                period = now - last_time;
                if (!seeded) begin
                    smoothed = period;
                    seeded   = 1'b1;
                end else begin
                    sum = SUM_W'(period) + SUM_W'(smoothed) * SUM_W'(SMOOTH_DIV - 4'd1);
                    smoothed = TIME_W'(sum / SUM_W'(SMOOTH_DIV));
                end
                divisor = DIV_W'(smoothed) * DIV_W'(edges);
                r.freq  = (divisor == '0) ? '0 : CLK_W'(DIV_W'(timer_clock) / divisor);
                lo = (target > tolerance) ? (HZ_W+1)'(target - tolerance) : '0;
                hi = (HZ_W+1)'(target) + (HZ_W+1)'(tolerance);
                r.valid  = 1'b1;
                r.detect = (r.freq >= CLK_W'(lo)) && (r.freq <= CLK_W'(hi));
            end
            last_time = now;
            have_last = 1'b1;
            owed_freqs.push_back(r);
        endfunction

        function int pending();
            return owed_freqs.size();
        endfunction

        task report_mismatch(string what, longint got, longint want);
            if (errors < 40)
                $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        // Compares one result transfer with the oldest owed frequency.
        task check_result(logic v, logic [CLK_W-1:0] f, logic d);
            t_freq_result e;
            if (owed_freqs.size() == 0) begin
                report_mismatch("result with nothing owed, freq", f, 0);
            end else begin
                e = owed_freqs.pop_front();
                results++;
                if (e.detect)
                    hits++;
                if (v !== e.valid)
                    report_mismatch("freq_valid", v, e.valid);
                if (f !== e.freq)
                    report_mismatch("frequency_hz", f, e.freq);
                if (d !== e.detect)
                    report_mismatch("beacon_detected", d, e.detect);
            end
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [TIME_W-1:0] i_capture_time = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_freq_valid;
    logic [CLK_W-1:0]  o_frequency_hz;
    logic              o_beacon_detected;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [CLK_W-1:0]  i_cfg_data = '0;

    frequency_board    board;
    int                gap_pct = 0;
    int                stall_pct = 0;
    int                cycles = 0;
    int                captures = 0;
    int                settings = 0;
    logic [TIME_W-1:0] clock_now = '0;

    beacon_frequency_detector_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_capture_time    (i_capture_time),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_freq_valid      (o_freq_valid),
        .o_frequency_hz    (o_frequency_hz),
        .o_beacon_detected (o_beacon_detected),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // The receiver stalls at random according to the current phase.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Every transfer on the three channels is seen here at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                board.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                board.predict_capture(i_capture_time);
            if (o_out_valid && i_out_ready)
                board.check_result(o_freq_valid, o_frequency_hz, o_beacon_detected);
        end
    end

    // Offers one timestamp, with random sender gaps, until it is transferred.
    task automatic send_capture(input logic [TIME_W-1:0] t);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_capture_time = t;
        do @(posedge i_clk); while (!o_in_ready);
        captures++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CLK_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Drops the capture valid and waits until every owed result has come.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [CLK_W-1:0] clk_hz, input logic [CLK_W-1:0] edges,
                                input logic [CLK_W-1:0] target, input logic [CLK_W-1:0] tol);
        drain();
        write_reg(REG_TIMER_CLOCK, clk_hz);
        write_reg(REG_EDGES, edges);
        write_reg(REG_TARGET, target);
        write_reg(REG_TOLERANCE, tol);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        settings++;
    endtask

    // Picks a register setting and the nominal edge spacing for one phase.
    task automatic pick_setting(output int unsigned base);
        int unsigned edges;
        int unsigned clk_hz;
        int unsigned target;
        edges = $urandom_range(16, 1);
        base  = $urandom_range(4000, 2);
        clk_hz = base * edges * $urandom_range(3000, 1);
        if (clk_hz > MAX_FREQ)
            clk_hz = MAX_FREQ;
        target = clk_hz / (base * edges);
        if (target > 65535)
            target = 65535;
        if ($urandom_range(3) == 0)
            program_regs(CLK_W'($urandom), CLK_W'($urandom), CLK_W'($urandom),
                         CLK_W'($urandom));
        else
            program_regs(CLK_W'(clk_hz), CLK_W'(edges), CLK_W'(target),
                         CLK_W'($urandom_range(target / 10 + 5, 0)));
    endtask

    // One well-formed edge spacing with jitter, or now and then a stray one.
    task automatic next_capture(input int unsigned base);
        logic [TIME_W-1:0] t;
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(2))
                0: t = $urandom;
                1: t = clock_now;
                default: t = clock_now + $urandom_range(4, 1);
            endcase
        end else begin
            t = clock_now + base - base / 16 + $urandom_range(base / 8);
        end
        clock_now = t;
        send_capture(t);
    endtask

    initial begin
        int unsigned base;
        board = new();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: an all-ones first edge, a wrapping period, the
        // smoothed period decaying to zero, then the largest period twice.
        send_capture(32'hFFFF_FFFF);
        send_capture(32'd2);
        repeat (4) send_capture(32'd5);
        send_capture(32'd4);
        send_capture(32'd3);

        // Zero divisor with a window holding only zero, widest clock field, and writes
        // outside the register map.
        program_regs(25'h1FF_FFFF, '0, '0, '0);
        write_reg(IDX_UNMAPPED_LO, 25'h000_0007);
        write_reg(IDX_UNMAPPED_HI, 25'h1FF_FFFF);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        send_capture(32'd103);
        send_capture(32'd103);

        // Upper field bits dropped on write; the widest window, which must not wrap.
        program_regs(CLK_W'(MAX_FREQ), 25'h1FF_FFE1, 25'h1FF_FFFF, 25'h000_FFFF);
        send_capture(32'd110);
        send_capture(32'd2000);

        // Tolerance above target, so the window starts at zero.
        program_regs(25'd1, 25'd16, 25'd10, 25'd500);
        send_capture(32'd2001);
        send_capture(32'hFFFF_0000);
        clock_now = 32'hFFFF_0000;

        // Random phases cycling through the pacing patterns.
        for (int ph = 0; ph < PHASES; ph++) begin
            gap_pct   = 0;
            stall_pct = 0;
            pick_setting(base);
            case (ph % 4)
                1: gap_pct = 73;
                2: stall_pct = 73;
                3: begin
                    gap_pct   = 38;
                    stall_pct = 38;
                end
                default: ;
            endcase
            repeat (PHASE_ITEMS) next_capture(base);
        end

        drain();
        $display("Sent %0d captures under %0d register settings with varied pacing.",
                 captures, settings);
        $display("Checked %0d results, %0d of them with a beacon flagged; %0d mismatches.",
                 board.results, board.hits, board.errors);
        if (board.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- beacon_frequency_detector_unit.f -----
sv/bfd_pkg.sv
sv/beacon_frequency_detector_unit.sv
test/tb.sv
